[rtl/rlse_pkg.sv]
// shared types, constants and helpers for the led strip bit encoder
// no dependencies
`default_nettype none

package rlse_pkg;

	// fixed widths
	localparam int unsigned PIX_W       = 11;
	localparam int unsigned CYC_W       = 16;
	localparam int unsigned MAP_W       = 12;
	localparam int unsigned NCOL_W      = 3;
	localparam int unsigned WIRE_W      = 32;
	localparam int unsigned BITCNT_W    = 5;
	localparam int unsigned CFG_ADDR_W  = 5;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned DEF_MAX_PIXELS = 1024;

	// color codes held in one map slot
	localparam logic [2:0] COL_WHITE = 3'd0;
	localparam logic [2:0] COL_RED   = 3'd1;
	localparam logic [2:0] COL_GREEN = 3'd2;
	localparam logic [2:0] COL_BLUE  = 3'd3;

	// register indexes
	typedef enum logic [2:0] {
		REG_BIT_PERIOD = 3'd0,
		REG_ZERO_HIGH  = 3'd1,
		REG_ONE_HIGH   = 3'd2,
		REG_NCOL       = 3'd3,
		REG_MAP        = 3'd4,
		REG_CHAIN      = 3'd5
	} reg_idx_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OVERRUN = 2'd1,
		ST_BAD_MAP = 2'd2
	} status_t;

	typedef struct packed {
		logic [CYC_W-1:0]  bit_period;
		logic [CYC_W-1:0]  zero_high;
		logic [CYC_W-1:0]  one_high;
		logic [NCOL_W-1:0] ncol;
		logic [MAP_W-1:0]  color_map;
		logic [PIX_W-1:0]  chain;
	} cfg_t;

	// one classified pixel handed from front to back
	typedef struct packed {
		logic [WIRE_W-1:0] wire_bits;
		logic              four;
		logic              last;
		status_t           status;
	} cmd_t;

	// byte sent for one map slot
	function automatic logic [7:0] color_byte(input logic [2:0] code,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		logic [7:0] res;
		case (code)
			COL_RED:   res = r;
			COL_GREEN: res = g;
			COL_BLUE:  res = b;
			default:   res = 8'd0;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

[rtl/rlse_cfg.sv]
// configuration registers behind the apb-style port
// depends on rlse_pkg
`default_nettype none

module rlse_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [rlse_pkg::CFG_ADDR_W-1:0]    paddr,
	input  wire logic [rlse_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic      [rlse_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                    pready,
	output rlse_pkg::cfg_t                          cfg
);
	import rlse_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_period <= CYC_W'(100);
			cfg_q.zero_high  <= CYC_W'(32);
			cfg_q.one_high   <= CYC_W'(64);
			cfg_q.ncol       <= NCOL_W'(3);
			cfg_q.color_map  <= MAP_W'(202);
			cfg_q.chain      <= PIX_W'(1024);
		end else if (wr_en) begin
			case (idx)
				REG_BIT_PERIOD: cfg_q.bit_period <= pwdata[CYC_W-1:0];
				REG_ZERO_HIGH:  cfg_q.zero_high  <= pwdata[CYC_W-1:0];
				REG_ONE_HIGH:   cfg_q.one_high   <= pwdata[CYC_W-1:0];
				REG_NCOL:       cfg_q.ncol       <= pwdata[NCOL_W-1:0];
				REG_MAP:        cfg_q.color_map  <= pwdata[MAP_W-1:0];
				REG_CHAIN:      cfg_q.chain      <= pwdata[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (idx)
			REG_BIT_PERIOD: prdata = CFG_DATA_W'(cfg_q.bit_period);
			REG_ZERO_HIGH:  prdata = CFG_DATA_W'(cfg_q.zero_high);
			REG_ONE_HIGH:   prdata = CFG_DATA_W'(cfg_q.one_high);
			REG_NCOL:       prdata = CFG_DATA_W'(cfg_q.ncol);
			REG_MAP:        prdata = CFG_DATA_W'(cfg_q.color_map);
			REG_CHAIN:      prdata = CFG_DATA_W'(cfg_q.chain);
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/rlse_front.sv]
// front end: takes pixels, tracks the frame position, checks and orders colors
// depends on rlse_pkg
`default_nettype none

module rlse_front #(
	parameter int unsigned MAX_PIXELS = rlse_pkg::DEF_MAX_PIXELS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire logic [7:0]     red,
	input  wire logic [7:0]     green,
	input  wire logic [7:0]     blue,
	input  wire logic           frame_last,
	input  wire rlse_pkg::cfg_t cfg,
	input  wire logic           cmdq_full,
	output logic                cmdq_wr,
	output rlse_pkg::cmd_t      cmdq_data
);
	import rlse_pkg::*;

	localparam int unsigned CMP_W = 17;
	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_PIXELS);

	logic [PIX_W-1:0] pixel_index_q;
	logic [PIX_W-1:0] limit;
	logic             four;
	logic             overrun;
	logic             bad_map;
	logic [2:0]       slot_code [4];

	assign cmdq_wr = push & ~cmdq_full;

	// classification of the incoming pixel
	always_comb begin
		limit = (CMP_W'(cfg.chain) > MAX_CMP) ? PIX_W'(MAX_PIXELS) : cfg.chain;
		four  = cfg.ncol >= NCOL_W'(4);
		for (int s = 0; s < 4; s++) begin
			slot_code[s] = cfg.color_map[3*s +: 3];
		end
		overrun = pixel_index_q >= limit;
		bad_map = slot_code[0][2] | slot_code[1][2] | slot_code[2][2]
			| (four & slot_code[3][2]);
		cmdq_data.four = four;
		cmdq_data.last = frame_last;
		if (overrun) begin
			cmdq_data.status = ST_OVERRUN;
		end else if (bad_map) begin
			cmdq_data.status = ST_BAD_MAP;
		end else begin
			cmdq_data.status = ST_OK;
		end
		for (int s = 0; s < 4; s++) begin
			cmdq_data.wire_bits[WIRE_W-1-8*s -: 8] =
				color_byte(slot_code[s], red, green, blue);
		end
	end

	// pixel position within the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_index_q <= '0;
		end else if (cmdq_wr) begin
			if (frame_last) begin
				pixel_index_q <= '0;
			end else if (!overrun && !bad_map) begin
				pixel_index_q <= pixel_index_q + PIX_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/rlse_cmd_fifo.sv]
// two-entry queue of classified pixels between front and back
// depends on rlse_pkg
`default_nettype none

module rlse_cmd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr,
	input  wire rlse_pkg::cmd_t wr_data,
	output logic                full,
	input  wire logic           rd,
	output rlse_pkg::cmd_t      rd_data,
	output logic                valid
);
	import rlse_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign full    = count_q == 2'd2;
	assign valid   = count_q != 2'd0;
	assign do_wr   = wr & ~full;
	assign do_rd   = rd & valid;
	assign rd_data = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

[rtl/rlse_back.sv]
// back end: shifts out one pulse slot per cycle into the result register
// while it is empty or popped; depends on rlse_pkg
`default_nettype none

module rlse_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire rlse_pkg::cfg_t            cfg,
	input  wire logic                      cmdq_valid,
	input  wire rlse_pkg::cmd_t            cmdq_data,
	output logic                           cmdq_rd,
	input  wire logic                      pop,
	output logic                           empty,
	output logic                           bit_sent,
	output logic [rlse_pkg::CYC_W-1:0]     high_cycles,
	output logic [rlse_pkg::CYC_W-1:0]     slot_cycles,
	output logic                           latch_slot,
	output logic [1:0]                     status,
	output logic                           run_end
);
	import rlse_pkg::*;

	cmd_t                cur_q;
	logic                cur_valid_q;
	logic [WIRE_W-1:0]   shift_q;
	logic [BITCNT_W-1:0] bit_cnt_q;
	logic                latch_q;
	logic                out_valid_q;

	logic                take;
	logic                fire;
	logic                is_err;
	logic                last_bit;
	logic                load;
	logic                done;
	logic                nx_bit;
	logic [CYC_W-1:0]    nx_high;
	logic                nx_latch;
	status_t             nx_status;
	logic                nx_end;

	// beat for the current slot
	always_comb begin
		take     = ~out_valid_q | pop;
		fire     = cur_valid_q & take;
		is_err   = cur_q.status != ST_OK;
		last_bit = bit_cnt_q == (cur_q.four ? BITCNT_W'(31) : BITCNT_W'(23));
		if (is_err) begin
			nx_bit    = 1'b0;
			nx_high   = '0;
			nx_latch  = 1'b0;
			nx_status = cur_q.status;
			nx_end    = 1'b1;
		end else if (latch_q) begin
			nx_bit    = 1'b0;
			nx_high   = '0;
			nx_latch  = 1'b1;
			nx_status = ST_OK;
			nx_end    = 1'b1;
		end else begin
			nx_bit    = shift_q[WIRE_W-1];
			nx_high   = shift_q[WIRE_W-1] ? cfg.one_high : cfg.zero_high;
			nx_latch  = 1'b0;
			nx_status = ST_OK;
			nx_end    = last_bit & ~cur_q.last;
		end
		done    = nx_end;
		load    = ~cur_valid_q | (fire & done);
		cmdq_rd = load & cmdq_valid;
	end

	// pixel sequencing control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			bit_cnt_q   <= '0;
			latch_q     <= 1'b0;
		end else if (load) begin
			cur_valid_q <= cmdq_valid;
			bit_cnt_q   <= '0;
			latch_q     <= 1'b0;
		end else if (fire) begin
			bit_cnt_q <= bit_cnt_q + BITCNT_W'(1);
			if (last_bit && cur_q.last && !is_err && !latch_q) begin
				latch_q <= 1'b1;
			end
		end
	end

	// current pixel and shift register
	always_ff @(posedge clk) begin
		if (cmdq_rd) begin
			cur_q   <= cmdq_data;
			shift_q <= cmdq_data.wire_bits;
		end else if (fire) begin
			shift_q <= {shift_q[WIRE_W-2:0], 1'b0};
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			bit_sent    <= nx_bit;
			high_cycles <= nx_high;
			slot_cycles <= cfg.bit_period;
			latch_slot  <= nx_latch;
			status      <= nx_status;
			run_end     <= nx_end;
		end
	end

	assign empty = ~out_valid_q;

endmodule

`default_nettype wire

[rtl/rgb_led_strip_bit_encoder_unit.sv]
// top level of the led strip bit encoder: config port, front, queue and back
// depends on rlse_pkg, rlse_cfg, rlse_front, rlse_cmd_fifo, rlse_back
`default_nettype none

// Each pixel pushed in becomes one result beat per data bit, most significant
// bit of each wire-order color byte first: 24 beats with three colors, 32 with
// four, plus one latch beat when the pixel ends a frame, or a single status
// beat when the pixel lies beyond the chain or the color map holds a bad code.
// Beats leave at one per cycle through the output register while the result
// side pops them and a pixel is waiting. A two-deep queue of classified
// pixels sits between the input and the bit shifter, so up to two further
// pixels are taken while one is being sent. Write configuration only while
// no pixel is in flight.
module rgb_led_strip_bit_encoder_unit #(
	parameter int unsigned MAX_PIXELS = rlse_pkg::DEF_MAX_PIXELS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [rlse_pkg::CFG_ADDR_W-1:0]    paddr,
	input  wire logic [rlse_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic      [rlse_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                    pready,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic [7:0]                         red,
	input  wire logic [7:0]                         green,
	input  wire logic [7:0]                         blue,
	input  wire logic                               frame_last,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic                                    bit_sent,
	output logic      [rlse_pkg::CYC_W-1:0]         high_cycles,
	output logic      [rlse_pkg::CYC_W-1:0]         slot_cycles,
	output logic                                    latch_slot,
	output logic      [1:0]                         status,
	output logic                                    run_end
);
	import rlse_pkg::*;

	cfg_t cfg;
	cmd_t cmdq_wr_data;
	cmd_t cmdq_rd_data;
	logic cmdq_wr;
	logic cmdq_rd;
	logic cmdq_valid;

	// configuration registers
	rlse_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// pixel intake and classification
	rlse_front #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.frame_last (frame_last),
		.cfg        (cfg),
		.cmdq_full  (full),
		.cmdq_wr    (cmdq_wr),
		.cmdq_data  (cmdq_wr_data)
	);

	// queue between front and back
	rlse_cmd_fifo u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmdq_wr),
		.wr_data (cmdq_wr_data),
		.full    (full),
		.rd      (cmdq_rd),
		.rd_data (cmdq_rd_data),
		.valid   (cmdq_valid)
	);

	// bit shifter and result register
	rlse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmdq_valid  (cmdq_valid),
		.cmdq_data   (cmdq_rd_data),
		.cmdq_rd     (cmdq_rd),
		.pop         (pop),
		.empty       (empty),
		.bit_sent    (bit_sent),
		.high_cycles (high_cycles),
		.slot_cycles (slot_cycles),
		.latch_slot  (latch_slot),
		.status      (status),
		.run_end     (run_end)
	);

endmodule

`default_nettype wire

[sim/rgb_led_strip_bit_encoder_unit_test.sv]
// self-checking testbench for the led strip bit encoder: apb register setup,
// pixel pushes and pulse beat checks against a built-in bit-level predictor
// depends on rlse_pkg and rgb_led_strip_bit_encoder_unit
`timescale 1ns / 100ps

module rgb_led_strip_bit_encoder_unit_test;
	import rlse_pkg::*;

	// one pulse beat as it leaves the block
	typedef struct {
		logic        bit_sent;
		logic [15:0] high_cycles;
		logic [15:0] slot_cycles;
		logic        latch_slot;
		status_t     status;
		logic        run_end;
	} pulse_t;

	// predictor and store of expected pulse beats
	class pulse_scoreboard;
		logic [15:0] bit_period;
		logic [15:0] zero_high;
		logic [15:0] one_high;
		logic [2:0]  ncol;
		logic [11:0] color_map;
		logic [10:0] chain;
		logic [10:0] pixel_pos;
		pulse_t      pending_pulses[$];
		int          errors;
		int          pixels;
		int          pulses;
		int          latches;
		int          overruns;
		int          bad_maps;

		function new();
			bit_period = 16'd100;
			zero_high  = 16'd32;
			one_high   = 16'd64;
			ncol       = 3'd3;
			color_map  = 12'd202;
			chain      = 11'd1024;
			pixel_pos  = '0;
			errors = 0;
			pixels = 0;
			pulses = 0;
			latches = 0;
			overruns = 0;
			bad_maps = 0;
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 40)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		function void set_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_BIT_PERIOD: bit_period = value[15:0];
				REG_ZERO_HIGH:  zero_high  = value[15:0];
				REG_ONE_HIGH:   one_high   = value[15:0];
				REG_NCOL:       ncol       = value[2:0];
				REG_MAP:        color_map  = value[11:0];
				REG_CHAIN:      chain      = value[10:0];
				default: ;
			endcase
		endfunction

		// expand one accepted pixel into its pulse beats
		function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
			int unsigned ncol_eff;
			int unsigned limit;
			logic [2:0]  code;
			logic [7:0]  colr;
			pulse_t      p;
			pixels++;
			ncol_eff = (ncol < 3) ? 3 : (ncol > 4) ? 4 : ncol;
			limit = (chain > DEF_MAX_PIXELS) ? DEF_MAX_PIXELS : chain;
			p.bit_sent = 1'b0;
			p.high_cycles = '0;
			p.slot_cycles = bit_period;
			p.latch_slot = 1'b0;
			p.status = ST_OK;
			p.run_end = 1'b1;
			// chain overrun wins over a bad map code
			if (pixel_pos >= limit) begin
				p.status = ST_OVERRUN;
			end else begin
				for (int s = 0; s < ncol_eff; s++)
					if (color_map[3*s +: 3] > COL_BLUE)
						p.status = ST_BAD_MAP;
			end
			if (p.status != ST_OK) begin
				if (p.status == ST_OVERRUN)
					overruns++;
				else
					bad_maps++;
				pending_pulses.push_back(p);
				if (last)
					pixel_pos = '0;
				return;
			end
			// data bits, msb first per wire-order byte
			for (int s = 0; s < ncol_eff; s++) begin
				code = color_map[3*s +: 3];
				case (code)
					COL_RED:   colr = r;
					COL_GREEN: colr = g;
					COL_BLUE:  colr = b;
					default:   colr = 8'd0;
				endcase
				for (int k = 7; k >= 0; k--) begin
					p.bit_sent = colr[k];
					p.high_cycles = colr[k] ? one_high : zero_high;
					p.run_end = !last && (s == ncol_eff - 1) && (k == 0);
					pending_pulses.push_back(p);
				end
			end
			// trailing latch slot after the frame
			if (last) begin
				p.bit_sent = 1'b0;
				p.high_cycles = '0;
				p.latch_slot = 1'b1;
				p.run_end = 1'b1;
				pending_pulses.push_back(p);
				pixel_pos = '0;
			end else begin
				pixel_pos = pixel_pos + 11'd1;
			end
		endfunction

		task check_pulse(pulse_t got);
			pulse_t exp;
			pulses++;
			if (pending_pulses.size() == 0) begin
				report_mismatch($sformatf("beat %0d arrived with nothing expected", pulses));
				return;
			end
			exp = pending_pulses.pop_front();
			if (exp.latch_slot)
				latches++;
			if (got.bit_sent !== exp.bit_sent)
				report_mismatch($sformatf("beat %0d bit_sent %b, expected %b",
					pulses, got.bit_sent, exp.bit_sent));
			if (got.high_cycles !== exp.high_cycles)
				report_mismatch($sformatf("beat %0d high_cycles %0d, expected %0d",
					pulses, got.high_cycles, exp.high_cycles));
			if (got.slot_cycles !== exp.slot_cycles)
				report_mismatch($sformatf("beat %0d slot_cycles %0d, expected %0d",
					pulses, got.slot_cycles, exp.slot_cycles));
			if (got.latch_slot !== exp.latch_slot)
				report_mismatch($sformatf("beat %0d latch_slot %b, expected %b",
					pulses, got.latch_slot, exp.latch_slot));
			if (got.status !== exp.status)
				report_mismatch($sformatf("beat %0d status %0d, expected %0d",
					pulses, got.status, exp.status));
			if (got.run_end !== exp.run_end)
				report_mismatch($sformatf("beat %0d run_end %b, expected %b",
					pulses, got.run_end, exp.run_end));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  push = 1'b0;
	logic                  full;
	logic [7:0]            red = '0;
	logic [7:0]            green = '0;
	logic [7:0]            blue = '0;
	logic                  frame_last = 1'b0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic                  bit_sent;
	logic [CYC_W-1:0]      high_cycles;
	logic [CYC_W-1:0]      slot_cycles;
	logic                  latch_slot;
	logic [1:0]            status;
	logic                  run_end;

	pulse_scoreboard sb;
	bit push_on = 1'b0;
	int send_idle_max = 4;
	int take_idle_max = 4;
	int settings = 0;

	rgb_led_strip_bit_encoder_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full),
		.red(red), .green(green), .blue(blue), .frame_last(frame_last),
		.empty(empty), .pop(pop),
		.bit_sent(bit_sent), .high_cycles(high_cycles), .slot_cycles(slot_cycles),
		.latch_slot(latch_slot), .status(status), .run_end(run_end)
	);

	always #6 clk = ~clk;

	// run limit
	initial begin
		#6_000_000;
		$display("rgb_led_strip_bit_encoder_unit_test: errors");
		$finish;
	end

	// apb write followed by a read back of the same register
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		logic [31:0] mask;
		logic [31:0] rd;
		case (idx)
			REG_NCOL:  mask = 32'h7;
			REG_MAP:   mask = 32'hfff;
			REG_CHAIN: mask = 32'h7ff;
			default:   mask = 32'hffff;
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if ((rd & mask) !== (value & mask))
			sb.report_mismatch($sformatf("register %s reads %h, expected %h",
				idx.name(), rd & mask, value & mask));
	endtask

	task automatic write_all(logic [15:0] period, logic [15:0] zh, logic [15:0] oh,
		logic [2:0] nc, logic [11:0] cmap, logic [10:0] ch);
		write_reg(REG_BIT_PERIOD, 32'(period));
		write_reg(REG_ZERO_HIGH, 32'(zh));
		write_reg(REG_ONE_HIGH, 32'(oh));
		write_reg(REG_NCOL, 32'(nc));
		write_reg(REG_MAP, 32'(cmap));
		write_reg(REG_CHAIN, 32'(ch));
		settings++;
	endtask

	// push one pixel, leaving push high at the accepting edge
	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
		int gap;
		gap = $urandom_range(0, send_idle_max);
		if (gap > 0) begin
			if (push_on)
				push <= 1'b0;
			push_on = 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		push_on = 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		frame_last <= last;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_pixel(r, g, b, last);
	endtask

	// hold the input until every expected beat is out, then let the block settle
	task automatic drain_results();
		if (push_on)
			push <= 1'b0;
		push_on = 1'b0;
		while (sb.pending_pulses.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [11:0] random_map();
		logic [11:0] m;
		for (int s = 0; s < 4; s++)
			m[3*s +: 3] = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(4, 7))
				: 3'($urandom_range(0, 3));
		return m;
	endfunction

	// one register setting with random frames of random pixels
	task automatic random_phase(int n_items, bit hold_mid);
		logic [2:0]  nc;
		logic [10:0] ch;
		int          ch_eff;
		int          frame_len;
		int          sent;
		sent = 0;
		drain_results();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: nc = 3'd3;
			4, 5, 6, 7: nc = 3'd4;
			default:    nc = 3'($urandom_range(0, 7));
		endcase
		case ($urandom_range(0, 19))
			0:          ch = 11'd0;
			1:          ch = 11'd2047;
			2, 3, 4:    ch = 11'($urandom_range(9, 2047));
			default:    ch = 11'($urandom_range(1, 8));
		endcase
		ch_eff = (ch > DEF_MAX_PIXELS) ? DEF_MAX_PIXELS : ch;
		write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), nc, random_map(), ch);
		while (sent < n_items) begin
			// mostly frames that fit the chain, some that run past it
			if ($urandom_range(0, 6) == 0)
				frame_len = $urandom_range(1, 12);
			else
				frame_len = $urandom_range(1, (ch_eff < 1) ? 1 : (ch_eff > 6) ? 6 : ch_eff);
			for (int i = 0; i < frame_len; i++) begin
				send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), i == frame_len - 1);
				sent++;
				if (hold_mid && sent == n_items / 2)
					drain_results();
			end
		end
	endtask

	// result side: random pop stalls, check every accepted beat
	task automatic take_pulses();
		int     stall;
		pulse_t got;
		forever begin
			stall = $urandom_range(0, take_idle_max);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			got.bit_sent = bit_sent;
			got.high_cycles = high_cycles;
			got.slot_cycles = slot_cycles;
			got.latch_slot = latch_slot;
			got.status = status_t'(status);
			got.run_end = run_end;
			sb.check_pulse(got);
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		fork
			take_pulses();
		join_none
		@(posedge clk);

		// reset setting: extremes of the color bytes and one latch
		send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
		send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
		send_pixel(8'h80, 8'h01, 8'h7e, 1'b1);
		drain_results();

		// four colors with a white slot, zero period, two-pixel chain overrun
		write_all(16'd0, 16'd0, 16'hffff, 3'd4, 12'd202, 11'd2);
		send_pixel(8'hff, 8'h00, 8'haa, 1'b0);
		send_pixel(8'h55, 8'hff, 8'h00, 1'b0);
		send_pixel(8'h12, 8'h34, 8'h56, 1'b0);
		send_pixel(8'h01, 8'h02, 8'h03, 1'b1);
		send_pixel(8'hfe, 8'hef, 8'h7f, 1'b1);
		drain_results();

		// color count below range, bad code in an unused slot, chain above max
		write_all(16'hffff, 16'hffff, 16'd0, 3'd0, 12'd3667, 11'd2047);
		send_pixel(8'hc3, 8'h3c, 8'h99, 1'b0);
		send_pixel(8'h00, 8'hff, 8'h00, 1'b1);
		drain_results();

		// color count above range puts the bad slot in use
		write_reg(REG_NCOL, 32'd7);
		send_pixel(8'h01, 8'h01, 8'h01, 1'b0);
		send_pixel(8'h02, 8'h02, 8'h02, 1'b1);
		drain_results();

		// bad code in slot 0, then an empty chain over a bad map
		write_reg(REG_NCOL, 32'd3);
		write_reg(REG_MAP, 32'd212);
		send_pixel(8'h5a, 8'ha5, 8'h0f, 1'b1);
		drain_results();
		write_reg(REG_CHAIN, 32'd0);
		send_pixel(8'hf0, 8'h0f, 8'h33, 1'b0);
		drain_results();
		write_reg(REG_MAP, 32'd202);
		send_pixel(8'haa, 8'hbb, 8'hcc, 1'b1);

		// random part, with stretches of no idling on either side
		for (int ph = 0; ph < 9; ph++) begin
			send_idle_max = (ph % 3 == 1) ? 0 : 4;
			take_idle_max = (ph % 4 == 2) ? 0 : 4;
			random_phase(55, ph == 2);
		end
		send_idle_max = 4;
		take_idle_max = 4;

		drain_results();
		repeat (40) @(posedge clk);
		$display("covered %0d pixels and %0d pulse beats (%0d latch slots) over %0d settings",
			sb.pixels, sb.pulses, sb.latches, settings + 1);
		$display("error pixels seen: %0d chain overruns, %0d bad color maps",
			sb.overruns, sb.bad_maps);
		if (sb.errors == 0) begin
			$display("rgb_led_strip_bit_encoder_unit_test: clean");
		end else begin
			$display("rgb_led_strip_bit_encoder_unit_test: errors");
		end
		$finish;
	end

endmodule

[rgb_led_strip_bit_encoder_unit.f]
rtl/rlse_pkg.sv
rtl/rlse_cfg.sv
rtl/rlse_front.sv
rtl/rlse_cmd_fifo.sv
rtl/rlse_back.sv
rtl/rgb_led_strip_bit_encoder_unit.sv
sim/rgb_led_strip_bit_encoder_unit_test.sv
